[hdl/bz_pkg.sv]
// Shared types and constants of the cubic Bezier point splatter.
package bz_pkg;

    localparam int COORD_W      = 10;
    localparam int PT_FRAC      = 16;
    localparam int PT_W         = COORD_W + PT_FRAC;
    localparam int PIX_W        = 12;
    localparam int LVL_W        = 8;
    localparam int AX_W         = 16;
    localparam int BX_W         = 17;
    localparam int SQA_W        = 32;
    localparam int D_W          = 32;
    localparam int DI_W         = 34;
    localparam int R_W          = 50;
    localparam int SQ_W         = 18;
    localparam int CAND_W       = 21;
    localparam int PROD_W       = 52;
    localparam int LVL_STEPS    = 8;
    localparam int LVL_SCALE    = 260100;   // 4 * 255 * 255
    localparam int QUEUE_DEPTH  = 8;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;
    localparam int FRAME_SIZE_DEF  = 1024;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam logic [LVL_W-1:0] FULL_LVL = 8'd255;

    typedef enum logic [2:0] {
        REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y,
        REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] p0_x;
        logic [COORD_W-1:0] p0_y;
        logic [COORD_W-1:0] p1_x;
        logic [COORD_W-1:0] p1_y;
        logic [COORD_W-1:0] p2_x;
        logic [COORD_W-1:0] p2_y;
        logic [COORD_W-1:0] p3_x;
        logic [COORD_W-1:0] p3_y;
    } pts_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] cx;
        logic signed [PIX_W-1:0] cy;
        logic signed [PIX_W-1:0] nx;
        logic signed [PIX_W-1:0] ny;
    } geo_t;

    typedef struct packed {
        geo_t             geo;
        logic [LVL_W-1:0] lvl_h;
        logic [LVL_W-1:0] lvl_v;
        logic [LVL_W-1:0] lvl_d;
    } item_t;

endpackage

[hdl/bz_level.sv]
// Pipelined bitwise search of the three neighbor intensities.
module bz_level (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  bz_pkg::geo_t             in_geo,
    input  logic [bz_pkg::R_W-1:0]   in_r,
    input  logic [bz_pkg::DI_W-1:0]  in_di [0:2],
    output logic                     out_valid,
    output bz_pkg::item_t            out_item
);
    import bz_pkg::*;

    logic [LVL_STEPS-1:0] v_reg;
    geo_t                 geo_reg [0:LVL_STEPS-1];
    logic [LVL_W-1:0]     n_reg   [0:LVL_STEPS-1][0:2];
    logic [SQ_W-1:0]      sq_reg  [0:LVL_STEPS-2][0:2];
    logic [R_W-1:0]       r_reg   [0:LVL_STEPS-2];
    logic [DI_W-1:0]      di_reg  [0:LVL_STEPS-2][0:2];

    // One intensity bit per stage, most significant first. The square of the
    // odd test value is advanced by shifts and adds from the previous one.
    for (genvar g = 0; g < LVL_STEPS; g++) begin : g_stage
        localparam int B  = LVL_STEPS - 1 - g;
        localparam int SH = B + 2;
        localparam int SQ_SH = 2 * B + 2;

        logic           v_in;
        geo_t           geo_in;
        logic [R_W-1:0] r_in;

        if (g == 0) begin : g_first
            assign v_in   = in_valid;
            assign geo_in = in_geo;
            assign r_in   = in_r;
        end else begin : g_next
            assign v_in   = v_reg[g-1];
            assign geo_in = geo_reg[g-1];
            assign r_in   = r_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            geo_reg[g] <= geo_in;
        end

        if (g < LVL_STEPS - 1) begin : g_fwd
            always_ff @(posedge clk) begin
                r_reg[g] <= r_in;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [LVL_W-1:0]  n_in;
            logic [SQ_W-1:0]   sq_in;
            logic [DI_W-1:0]   di_in;
            logic [CAND_W-1:0] q_old;
            logic [CAND_W-1:0] cand_sq;
            logic [PROD_W-1:0] prod;
            logic              pass;

            if (g == 0) begin : g_first
                assign n_in  = '0;
                assign sq_in = SQ_W'(1);
                assign di_in = in_di[l];
            end else begin : g_next
                assign n_in  = n_reg[g-1][l];
                assign sq_in = sq_reg[g-1][l];
                assign di_in = di_reg[g-1][l];
            end

            assign q_old   = {{(CAND_W-LVL_W-1){1'b0}}, n_in, 1'b0} - CAND_W'(1);
            assign cand_sq = CAND_W'(sq_in) + (q_old << SH) + (CAND_W'(1) << SQ_SH);
            assign prod    = PROD_W'(cand_sq[SQ_W-1:0]) * PROD_W'(di_in);
            assign pass    = prod <= PROD_W'(r_in);

            always_ff @(posedge clk) begin
                if (pass)
                begin
                    n_reg[g][l] <= n_in | (LVL_W'(1) << B);
                end
                else
                begin
                    n_reg[g][l] <= n_in;
                end
            end

            if (g < LVL_STEPS - 1) begin : g_fwd
                always_ff @(posedge clk) begin
                    di_reg[g][l] <= di_in;
                    if (pass)
                    begin
                        sq_reg[g][l] <= cand_sq[SQ_W-1:0];
                    end
                    else
                    begin
                        sq_reg[g][l] <= sq_in;
                    end
                end
            end
        end
    end

    assign out_valid      = v_reg[LVL_STEPS-1];
    assign out_item.geo   = geo_reg[LVL_STEPS-1];
    assign out_item.lvl_h = n_reg[LVL_STEPS-1][0];
    assign out_item.lvl_v = n_reg[LVL_STEPS-1][1];
    assign out_item.lvl_d = n_reg[LVL_STEPS-1][2];

endmodule

[hdl/bz_front.sv]
// Front part: curve evaluation, pixel classification and distance terms.
module bz_front #(
    parameter int T_FRAC_BITS = bz_pkg::T_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [T_FRAC_BITS:0] t_frac,
    input  bz_pkg::pts_t         pts,
    output logic                 out_valid,
    output bz_pkg::item_t        out_item
);
    import bz_pkg::*;

    localparam int TF = T_FRAC_BITS;
    localparam int AW = PT_W + TF + 2;
    localparam logic [TF:0] ONE_T = (TF+1)'(1) << TF;
    localparam logic [AX_W-1:0] HALF_P = AX_W'(1) << (PT_FRAC - 1);
    localparam logic [BX_W-1:0] ONE_P  = BX_W'(1) << PT_FRAC;

    function automatic logic [PT_W-1:0] lerp(input logic [PT_W-1:0] a,
                                             input logic [PT_W-1:0] b,
                                             input logic [TF:0] t);
        logic [AW-1:0] acc;
        acc = AW'(a) * AW'(ONE_T - t) + AW'(b) * AW'(t) + AW'(ONE_T >> 1);
        return acc[TF +: PT_W];
    endfunction

    function automatic logic [PT_W-1:0] pt(input logic [COORD_W-1:0] c);
        return {c, {PT_FRAC{1'b0}}};
    endfunction

    logic [7:0]      v_reg;
    logic [TF:0]     t0_reg, t1_reg, t2_reg;
    logic [PT_W-1:0] l1x_reg [0:2];
    logic [PT_W-1:0] l1y_reg [0:2];
    logic [PT_W-1:0] l2x_reg [0:1];
    logic [PT_W-1:0] l2y_reg [0:1];
    logic [PT_W-1:0] px_reg, py_reg;
    geo_t            geo4_reg, geo5_reg, geo6_reg, geo7_reg;
    logic [AX_W-1:0] ax_reg, ay_reg;
    logic [BX_W-1:0] bx_reg, by_reg;
    logic [SQA_W-1:0] ax2_reg, ay2_reg;
    logic [DI_W-1:0] bx2_reg, by2_reg;
    logic [D_W-1:0]  d_reg;
    logic [DI_W-1:0] di6_reg [0:2];
    logic [DI_W-1:0] di7_reg [0:2];
    logic [R_W-1:0]  r_reg;

    logic [TF:0]     t_sat;
    logic [AX_W-1:0] fx, fy, ax_next, ay_next;
    logic            sx, sy;
    geo_t            geo_next;

    assign t_sat = (t_frac > ONE_T) ? ONE_T : t_frac;

    always_comb begin
        fx = px_reg[PT_FRAC-1:0];
        fy = py_reg[PT_FRAC-1:0];
        sx = fx[PT_FRAC-1];
        sy = fy[PT_FRAC-1];
        ax_next = sx ? (fx - HALF_P) : (HALF_P - fx);
        ay_next = sy ? (fy - HALF_P) : (HALF_P - fy);
        geo_next.cx = PIX_W'(px_reg[PT_W-1:PT_FRAC]);
        geo_next.cy = PIX_W'(py_reg[PT_W-1:PT_FRAC]);
        geo_next.nx = sx ? geo_next.cx + PIX_W'(1) : geo_next.cx - PIX_W'(1);
        geo_next.ny = sy ? geo_next.cy + PIX_W'(1) : geo_next.cy - PIX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        // de Casteljau, one level per stage
        t0_reg     <= t_sat;
        l1x_reg[0] <= lerp(pt(pts.p0_x), pt(pts.p1_x), t0_reg);
        l1x_reg[1] <= lerp(pt(pts.p1_x), pt(pts.p2_x), t0_reg);
        l1x_reg[2] <= lerp(pt(pts.p2_x), pt(pts.p3_x), t0_reg);
        l1y_reg[0] <= lerp(pt(pts.p0_y), pt(pts.p1_y), t0_reg);
        l1y_reg[1] <= lerp(pt(pts.p1_y), pt(pts.p2_y), t0_reg);
        l1y_reg[2] <= lerp(pt(pts.p2_y), pt(pts.p3_y), t0_reg);
        t1_reg     <= t0_reg;
        l2x_reg[0] <= lerp(l1x_reg[0], l1x_reg[1], t1_reg);
        l2x_reg[1] <= lerp(l1x_reg[1], l1x_reg[2], t1_reg);
        l2y_reg[0] <= lerp(l1y_reg[0], l1y_reg[1], t1_reg);
        l2y_reg[1] <= lerp(l1y_reg[1], l1y_reg[2], t1_reg);
        t2_reg     <= t1_reg;
        px_reg     <= lerp(l2x_reg[0], l2x_reg[1], t2_reg);
        py_reg     <= lerp(l2y_reg[0], l2y_reg[1], t2_reg);
        // pixel, side and offsets from the centre
        geo4_reg   <= geo_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= ONE_P - BX_W'(ax_next);
        by_reg     <= ONE_P - BX_W'(ay_next);
        // squares
        geo5_reg   <= geo4_reg;
        ax2_reg    <= SQA_W'(ax_reg) * SQA_W'(ax_reg);
        ay2_reg    <= SQA_W'(ay_reg) * SQA_W'(ay_reg);
        bx2_reg    <= DI_W'(bx_reg) * DI_W'(bx_reg);
        by2_reg    <= DI_W'(by_reg) * DI_W'(by_reg);
        // squared distances
        geo6_reg   <= geo5_reg;
        d_reg      <= ax2_reg + ay2_reg;
        di6_reg[0] <= bx2_reg + DI_W'(ay2_reg);
        di6_reg[1] <= DI_W'(ax2_reg) + by2_reg;
        di6_reg[2] <= bx2_reg + by2_reg;
        // scaled bound for the search
        geo7_reg   <= geo6_reg;
        r_reg      <= R_W'(d_reg) * R_W'(LVL_SCALE);
        di7_reg    <= di6_reg;
    end

    bz_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[7]),
        .in_geo    (geo7_reg),
        .in_r      (r_reg),
        .in_di     (di7_reg),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

[hdl/bz_queue.sv]
// Small FIFO between the front and back parts.
module bz_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bz_pkg::item_t push_item,
    input  logic          pop,
    output logic          empty,
    output bz_pkg::item_t head_item
);
    import bz_pkg::*;

    item_t             mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign empty     = (cnt_reg == '0);
    assign head_item = mem[rd_reg];

    always_ff @(posedge clk) begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

[hdl/bz_emit.sv]
// Back part: sends the four pixel writes of each item in turn.
module bz_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  bz_pkg::item_t                    head_item,
    output logic                             pop,
    output logic                             strobe,
    output logic signed [bz_pkg::PIX_W-1:0]  pix_x,
    output logic signed [bz_pkg::PIX_W-1:0]  pix_y,
    output logic [bz_pkg::LVL_W-1:0]         intensity,
    output logic                             last
);
    import bz_pkg::*;

    typedef enum logic [1:0] { PH_CENTER, PH_HORIZ, PH_VERT, PH_DIAG } phase_t;

    phase_t phase_reg;
    logic   have_reg;
    item_t  hold_reg;

    assign pop    = !empty && (!have_reg || phase_reg == PH_DIAG);
    assign strobe = have_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg <= PH_CENTER;
            have_reg  <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg <= PH_CENTER;
            have_reg  <= 1'b1;
        end
        else if (have_reg)
        begin
            unique case (phase_reg)
                PH_CENTER: phase_reg <= PH_HORIZ;
                PH_HORIZ:  phase_reg <= PH_VERT;
                PH_VERT:   phase_reg <= PH_DIAG;
                PH_DIAG:   have_reg  <= 1'b0;
                default:   phase_reg <= PH_CENTER;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (pop)
        begin
            hold_reg <= head_item;
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_CENTER:
            begin
                pix_x = hold_reg.geo.cx;  pix_y = hold_reg.geo.cy;
                intensity = FULL_LVL;     last = 1'b0;
            end
            PH_HORIZ:
            begin
                pix_x = hold_reg.geo.nx;  pix_y = hold_reg.geo.cy;
                intensity = hold_reg.lvl_h; last = 1'b0;
            end
            PH_VERT:
            begin
                pix_x = hold_reg.geo.cx;  pix_y = hold_reg.geo.ny;
                intensity = hold_reg.lvl_v; last = 1'b0;
            end
            default:
            begin
                pix_x = hold_reg.geo.nx;  pix_y = hold_reg.geo.ny;
                intensity = hold_reg.lvl_d; last = 1'b1;
            end
        endcase
    end

endmodule

[hdl/cubic_bezier_point_splatter_top.sv]
// Top level of the cubic Bezier point splatter.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------
//  command   | start / busy            | t_frac (Q1.T_FRAC_BITS, t = 1 at 2^T)
//  result    | strobe (one cycle each) | pix_x, pix_y, intensity, last
//  config    | APB psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// An item is taken when start is high and busy is low. The front pipeline
// (t capture, 3 de Casteljau levels, geometry, squares, sums, scaling, 8
// search steps) feeds the queue; the back then sends the four pixel writes
// of each item one per cycle, so the sustained item rate is set by the
// single result port. Items may enter back to back until the credit count
// (queue depth of 8 items) is used up. The receiver cannot stall: results
// are shown for exactly one cycle. Reset clears all control state at once;
// control point registers reset to 0.
module cubic_bezier_point_splatter_top #(
    parameter int FRAME_SIZE  = bz_pkg::FRAME_SIZE_DEF,
    parameter int T_FRAC_BITS = bz_pkg::T_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [T_FRAC_BITS:0]              t_frac,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bz_pkg::ADDR_W-1:0]         paddr,
    input  logic [bz_pkg::DATA_W-1:0]         pwdata,
    output logic [bz_pkg::DATA_W-1:0]         prdata,
    output logic                              pready,
    output logic                              strobe,
    output logic signed [bz_pkg::PIX_W-1:0]   pix_x,
    output logic signed [bz_pkg::PIX_W-1:0]   pix_y,
    output logic [bz_pkg::LVL_W-1:0]          intensity,
    output logic                              last
);
    import bz_pkg::*;

    localparam int SAT_W = 13;

    pts_t              pts_reg;
    logic [QCNT_W-1:0] credit_reg;
    logic              accept, pop, q_push, q_empty, cfg_wr;
    item_t             front_item, head_item;
    reg_idx_t          idx;
    logic [COORD_W-1:0] wval;

    // Hold off new items once every queue slot is spoken for.
    assign busy   = (credit_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Clamp a written coordinate to the frame.
    always_comb begin
        wval = pwdata[COORD_W-1:0];
        if (SAT_W'(wval) > SAT_W'(FRAME_SIZE - 1))
        begin
            wval = COORD_W'(FRAME_SIZE - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pts_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + QCNT_W'(accept) - QCNT_W'(pop);
            if (cfg_wr)
            begin
                unique case (idx)
                    REG_P0_X: pts_reg.p0_x <= wval;
                    REG_P0_Y: pts_reg.p0_y <= wval;
                    REG_P1_X: pts_reg.p1_x <= wval;
                    REG_P1_Y: pts_reg.p1_y <= wval;
                    REG_P2_X: pts_reg.p2_x <= wval;
                    REG_P2_Y: pts_reg.p2_y <= wval;
                    REG_P3_X: pts_reg.p3_x <= wval;
                    REG_P3_Y: pts_reg.p3_y <= wval;
                    default:  pts_reg <= pts_reg;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_P0_X: prdata = DATA_W'(pts_reg.p0_x);
            REG_P0_Y: prdata = DATA_W'(pts_reg.p0_y);
            REG_P1_X: prdata = DATA_W'(pts_reg.p1_x);
            REG_P1_Y: prdata = DATA_W'(pts_reg.p1_y);
            REG_P2_X: prdata = DATA_W'(pts_reg.p2_x);
            REG_P2_Y: prdata = DATA_W'(pts_reg.p2_y);
            REG_P3_X: prdata = DATA_W'(pts_reg.p3_x);
            REG_P3_Y: prdata = DATA_W'(pts_reg.p3_y);
            default:  prdata = '0;
        endcase
    end

    bz_front #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .t_frac    (t_frac),
        .pts       (pts_reg),
        .out_valid (q_push),
        .out_item  (front_item)
    );

    bz_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    bz_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head_item (head_item),
        .pop       (pop),
        .strobe    (strobe),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .intensity (intensity),
        .last      (last)
    );

endmodule
